// ===== sv/trr_pkg.sv =====
// ----------------------------------------------------------------------------
// TLB refill package
// Request codes, channel item types and the token that walks the entry chain.
// ----------------------------------------------------------------------------
`default_nettype none

package trr_pkg;

  localparam int PAGE_W  = 20;
  localparam int INDEX_W = 6;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_WRPROT = 2'd1;
  localparam logic [1:0] REQ_INVAL  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PAGE_W-1:0] virt_page;
    logic [PAGE_W-1:0] phys_page;
  } trr_in_t;

  typedef struct packed {
    logic               status;
    logic [INDEX_W-1:0] entry_index;
    logic               evicted;
  } trr_out_t;

  // Request token handed from cell to cell.
  typedef struct packed {
    logic              active;
    logic [1:0]        req;
    logic [PAGE_W-1:0] virt;
    logic [PAGE_W-1:0] phys;
    logic              full;
    logic              done;
    logic              evicted;
  } trr_tok_t;

endpackage

`default_nettype wire

// ===== sv/trr_cell.sv =====
// ----------------------------------------------------------------------------
// TLB entry cell
// Holds one table entry, acts on the passing request token and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_cell import trr_pkg::*; #(
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic [IW-1:0] victim,
  input  wire trr_tok_t      tok_in,
  input  wire logic [IW-1:0] idx_in,
  output trr_tok_t           tok_out,
  output logic [IW-1:0]      idx_out
);

  logic [PAGE_W-1:0] virt;
  logic [PAGE_W-1:0] phys;
  logic              valid;
  logic              writable;

  logic              is_ins;
  logic              is_mat;
  logic              take_ins;
  logic              take_mat;
  trr_tok_t          tok_next;
  logic [IW-1:0]     idx_next;

  always_comb begin
    is_ins   = tok_in.active && !tok_in.done && (tok_in.req == REQ_INSERT);
    is_mat   = tok_in.active && !tok_in.done &&
               ((tok_in.req == REQ_WRPROT) || (tok_in.req == REQ_INVAL));
    // A full table replaces the victim entry; otherwise the first free one wins.
    take_ins = is_ins && (tok_in.full ? (victim == IW'(INDEX)) : !valid);
    take_mat = is_mat && valid && (virt == tok_in.virt);
    tok_next = tok_in;
    idx_next = idx_in;
    if (take_ins || take_mat) begin
      tok_next.done = 1'b1;
      idx_next      = IW'(INDEX);
    end
    if (take_ins) begin
      tok_next.evicted = tok_in.full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      writable <= 1'b0;
      tok_out  <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
      if (take_ins) begin
        valid    <= 1'b1;
        writable <= 1'b1;
      end
      if (take_mat && (tok_in.req == REQ_WRPROT)) begin
        writable <= 1'b0;
      end
      if (take_mat && (tok_in.req == REQ_INVAL)) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_out <= idx_next;
      if (take_ins) begin
        virt <= tok_in.virt;
        phys <= tok_in.phys;
      end
      if (take_mat && (tok_in.req == REQ_WRPROT)) begin
        phys <= tok_in.phys;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tlb_refill_round_robin.sv =====
// ----------------------------------------------------------------------------
// TLB refill table, first free then round-robin replacement
// Fully associative table built as a row of entry cells; a request walks it.
// ----------------------------------------------------------------------------
// An accepted item is held in the request register, its token walks the row of ENTRIES
// cells, one register per cell, and its result is held in the result register.
// A new item is taken only once the previous one has left the cell chain; it can be
// taken while the previous result still waits at the output.
// Reset: all entries invalid, victim pointer and valid count cleared.
`default_nettype none

module tlb_refill_round_robin import trr_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire trr_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output trr_out_t      out_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  trr_tok_t      tok [0:ENTRIES];
  logic [IW-1:0] idx [0:ENTRIES];
  logic [ENTRIES:0] tok_act;

  trr_tok_t      tok0;
  logic          busy;
  logic [IW-1:0] victim;
  logic [IW-1:0] victim_next;
  logic [CW-1:0] valid_count;
  logic [CW-1:0] valid_count_next;
  logic          adv;
  logic          fin;
  logic          accept;
  trr_tok_t      tok_end;
  trr_out_t      res;

  assign tok[0]  = tok0;
  assign idx[0]  = '0;
  assign tok_end = tok[ENTRIES];

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      trr_cell #(
        .IW    (IW),
        .INDEX (g)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .victim  (victim),
        .tok_in  (tok[g]),
        .idx_in  (idx[g]),
        .tok_out (tok[g+1]),
        .idx_out (idx[g+1])
      );
    end
    for (g = 0; g <= ENTRIES; g++) begin : g_act
      assign tok_act[g] = tok[g].active;
    end
  endgenerate

  // The chain freezes only when a finished item cannot enter the output register.
  assign adv      = !(tok_end.active && out_valid && !out_ready);
  assign fin      = tok_end.active && adv;
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    res.status      = ((tok_end.req == REQ_WRPROT) || (tok_end.req == REQ_INVAL)) &&
                      !tok_end.done;
    res.entry_index = INDEX_W'(idx[ENTRIES]);
    res.evicted     = tok_end.evicted;

    valid_count_next = valid_count;
    if ((tok_end.req == REQ_INSERT) && !tok_end.evicted) begin
      valid_count_next = valid_count + CW'(1);
    end else if ((tok_end.req == REQ_INVAL) && tok_end.done) begin
      valid_count_next = valid_count - CW'(1);
    end

    victim_next = victim;
    if (tok_end.evicted) begin
      victim_next = (victim == IW'(ENTRIES - 1)) ? '0 : victim + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      victim      <= '0;
      valid_count <= '0;
      tok0        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        tok0.active  <= 1'b1;
        tok0.req     <= in_data.req_type;
        tok0.virt    <= in_data.virt_page;
        tok0.phys    <= in_data.phys_page;
        tok0.full    <= (valid_count == CW'(ENTRIES));
        tok0.done    <= 1'b0;
        tok0.evicted <= 1'b0;
        busy         <= 1'b1;
      end else if (adv) begin
        tok0.active <= 1'b0;
      end
      if (fin) begin
        busy        <= 1'b0;
        out_valid   <= 1'b1;
        valid_count <= valid_count_next;
        victim      <= victim_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_data <= res;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_act) <= 1)
    else $error("more than one request token in the cell chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok_act == '0))
    else $error("request token present while block is idle");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> tok_act[0])
    else $error("accepted item did not enter the cell chain");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CW'(ENTRIES))
    else $error("valid entry count exceeds table size");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (tok_end.active && tok_end.evicted) |-> (valid_count == CW'(ENTRIES)))
    else $error("eviction reported while table was not full");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLB refill table testbench
// Drives insert, write-protect, invalidate and unused requests through the
// valid/ready channels with random gaps and stalls. Results listed in directed
// rows or predicted by a behavioral copy of the table are compared field by field.
// ----------------------------------------------------------------------------

module tb;
  import trr_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int LATENCY      = ENTRIES + 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 900;
  localparam int POOL_DEPTH   = 128;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    trr_in_t  req;
    bit       known;
    trr_out_t result;
  } tlb_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  trr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  trr_out_t out_data;

  // Shadow copy of the table.
  logic [PAGE_W-1:0] shadow_virt [ENTRIES];
  logic [PAGE_W-1:0] shadow_phys [ENTRIES];
  bit                shadow_valid [ENTRIES];
  bit                shadow_writable [ENTRIES];
  int                shadow_victim;

  trr_out_t          pending_results [$];
  logic [PAGE_W-1:0] inserted_pages [$];
  tlb_row_t          directed_rows [$];
  int                errors = 0;
  int                idle_cycles = 0;
  bit                burst = 1'b0;

  tlb_refill_round_robin #(.ENTRIES(ENTRIES)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic void clear_shadow();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      shadow_virt[i]     = '0;
      shadow_phys[i]     = '0;
      shadow_valid[i]    = 1'b0;
      shadow_writable[i] = 1'b0;
    end
    shadow_victim = 0;
  endfunction

  // Applies one request to the shadow table and returns its result item.
  function automatic trr_out_t apply_request(trr_in_t r);
    trr_out_t res;
    int hit;
    int slot;
    int i;
    res  = '0;
    hit  = -1;
    slot = -1;
    // Walk downward so the lowest-numbered candidate wins.
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_virt[i] == r.virt_page) hit = i;
      if (!shadow_valid[i]) slot = i;
    end
    case (r.req_type)
      REQ_INSERT: begin
        if (slot < 0) begin
          slot = shadow_victim;
          shadow_victim = (shadow_victim + 1) % ENTRIES;
          res.evicted = 1'b1;
        end
        shadow_virt[slot]     = r.virt_page;
        shadow_phys[slot]     = r.phys_page;
        shadow_valid[slot]    = 1'b1;
        shadow_writable[slot] = 1'b1;
        res.entry_index = slot[INDEX_W-1:0];
      end
      REQ_WRPROT, REQ_INVAL: begin
        if (hit < 0) begin
          res.status = 1'b1;
        end else begin
          if (r.req_type == REQ_WRPROT) begin
            shadow_phys[hit]     = r.phys_page;
            shadow_writable[hit] = 1'b0;
          end else begin
            shadow_valid[hit] = 1'b0;
          end
          res.entry_index = hit[INDEX_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_row(logic [1:0] req, logic [PAGE_W-1:0] vp,
                                  logic [PAGE_W-1:0] pp, bit known, logic st,
                                  logic [INDEX_W-1:0] idx, logic ev);
    tlb_row_t row;
    row.req.req_type       = req;
    row.req.virt_page      = vp;
    row.req.phys_page      = pp;
    row.known              = known;
    row.result.status      = st;
    row.result.entry_index = idx;
    row.result.evicted     = ev;
    directed_rows.push_back(row);
  endfunction

  // Mostly inserts and lookups of pages inserted earlier, with some noise.
  // The insert share changes by phase so the table both fills and drains.
  function automatic trr_in_t random_request(int phase);
    trr_in_t r;
    int pick;
    int insert_share;
    r.virt_page  = PAGE_W'($urandom);
    r.phys_page  = PAGE_W'($urandom);
    insert_share = (phase == 0) ? 70 : (phase == 1) ? 45 : 25;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.req_type = REQ_UNUSED;
    end else if (pick < 3 + insert_share) begin
      r.req_type = REQ_INSERT;
      // A few small page numbers make duplicate entries likely.
      if ($urandom_range(0, 3) == 0) r.virt_page = PAGE_W'($urandom_range(0, 7));
      inserted_pages.push_back(r.virt_page);
      if (inserted_pages.size() > POOL_DEPTH) void'(inserted_pages.pop_front());
    end else begin
      r.req_type = $urandom_range(0, 1) ? REQ_WRPROT : REQ_INVAL;
      if (inserted_pages.size() > 0 && $urandom_range(0, 9) != 0)
        r.virt_page = inserted_pages[$urandom_range(0, inserted_pages.size() - 1)];
    end
    return r;
  endfunction

  // Offers one request item and returns the predicted result once accepted.
  task automatic issue_request(input trr_in_t r, output trr_out_t predicted);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = apply_request(r);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    trr_out_t predicted;
    int n;
    clear_shadow();
    // After reset nothing is valid, so even page zero misses.
    add_row(REQ_INVAL,  20'h00000, 20'h00000, 1, 1'b1, 6'd0, 1'b0);
    add_row(REQ_WRPROT, 20'h00000, 20'hFFFFF, 1, 1'b1, 6'd0, 1'b0);
    add_row(REQ_INSERT, 20'hFFFFF, 20'hFFFFF, 1, 1'b0, 6'd0, 1'b0);
    add_row(REQ_INSERT, 20'h00000, 20'h00000, 1, 1'b0, 6'd1, 1'b0);
    add_row(REQ_INSERT, 20'hFFFFF, 20'h00000, 1, 1'b0, 6'd2, 1'b0);
    add_row(REQ_WRPROT, 20'hFFFFF, 20'h12345, 1, 1'b0, 6'd0, 1'b0);
    add_row(REQ_INVAL,  20'hFFFFF, 20'h00000, 1, 1'b0, 6'd0, 1'b0);
    add_row(REQ_WRPROT, 20'hFFFFF, 20'hABCDE, 1, 1'b0, 6'd2, 1'b0);
    add_row(REQ_INVAL,  20'hFFFFF, 20'hFFFFF, 1, 1'b0, 6'd2, 1'b0);
    add_row(REQ_INVAL,  20'hFFFFF, 20'hFFFFF, 1, 1'b1, 6'd0, 1'b0);
    add_row(REQ_UNUSED, 20'hFFFFF, 20'hFFFFF, 1, 1'b0, 6'd0, 1'b0);
    add_row(REQ_INSERT, 20'h5A5A5, 20'hA5A5A, 1, 1'b0, 6'd0, 1'b0);
    add_row(REQ_INVAL,  20'h00000, 20'h00000, 1, 1'b0, 6'd1, 1'b0);
    add_row(REQ_INSERT, 20'h00001, 20'h80000, 1, 1'b0, 6'd1, 1'b0);
    add_row(REQ_WRPROT, 20'h5A5A5, 20'hFFFFF, 1, 1'b0, 6'd0, 1'b0);
    add_row(REQ_UNUSED, 20'h00000, 20'h00000, 1, 1'b0, 6'd0, 1'b0);
    add_row(REQ_INVAL,  20'h12345, 20'h54321, 1, 1'b1, 6'd0, 1'b0);
    add_row(REQ_INSERT, 20'h80000, 20'h7FFFF, 0, 1'b0, 6'd0, 1'b0);
    add_row(REQ_WRPROT, 20'h00001, 20'h00001, 0, 1'b0, 6'd0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      issue_request(directed_rows[k].req, predicted);
      pending_results.push_back(directed_rows[k].known ? directed_rows[k].result
                                                       : predicted);
    end
    in_valid <= 1'b0;
    wait_for_drain();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      burst = ((n / 100) % 4) == 3;
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait_for_drain();
      end
      issue_request(random_request((n / 150) % 3), predicted);
      pending_results.push_back(predicted);
    end
    in_valid <= 1'b0;

    wait_for_drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stalls, then check each item against the oldest
  // prediction.
  initial begin
    trr_out_t want;
    int stall;
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result item arrived with no request pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index,
                 out_data.entry_index);
          errors++;
        end
        if (out_data.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, out_data.evicted);
          errors++;
        end
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
